// File: hw/rtl/sil_pkg.sv
`timescale 1ns / 1ps

package sil_pkg;

  localparam int unsigned ValueWidth = 32;

  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CMP,
    CELL_SHIFT_IN,
    CELL_ROTATE,
    CELL_CLEAR
  } cell_op_e;

  typedef struct packed {
    cell_op_e              op;
    logic                  is_insert;
    logic [ValueWidth-1:0] value;
  } cell_ctrl_t;

endpackage

// File: hw/rtl/sil_cell.sv
`timescale 1ns / 1ps

module sil_cell
  import sil_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cell_ctrl_t            ctrl_i,
  input  logic [ValueWidth-1:0] prev_value_i,
  input  logic                  prev_valid_i,
  input  logic                  prev_mask_i,
  input  logic [ValueWidth-1:0] next_value_i,
  input  logic                  next_valid_i,
  input  logic [ValueWidth-1:0] head_value_i,
  input  logic                  mask_i,
  output logic [ValueWidth-1:0] value_o,
  output logic                  valid_o,
  output logic                  hit_o
);

  logic [ValueWidth-1:0] value_q, value_d;
  logic                  valid_q, valid_d;
  logic                  hit_q, hit_d;
  logic                  tail;
  logic                  not_less;

  assign tail     = valid_q && !next_valid_i;
  assign not_less = !($signed(value_q) < $signed(ctrl_i.value));

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    hit_d   = hit_q;
    unique case (ctrl_i.op)
      CELL_HOLD: begin
      end
      CELL_CMP: begin
        hit_d = !valid_q || (ctrl_i.is_insert && not_less);
      end
      CELL_SHIFT_IN: begin
        if (mask_i) begin
          if (!prev_mask_i) begin
            value_d = ctrl_i.value;
            valid_d = 1'b1;
          end else begin
            value_d = prev_value_i;
            valid_d = prev_valid_i;
          end
        end
      end
      CELL_ROTATE: begin
        if (valid_q) begin
          value_d = tail ? head_value_i : next_value_i;
        end
      end
      CELL_CLEAR: begin
        valid_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign valid_o = valid_q;
  assign hit_o   = hit_q;

endmodule

// File: hw/rtl/sorted_insertion_list.sv
`timescale 1ns / 1ps

// A row of DEPTH cells holds the list head first, one entry per cell. An append, sorted
// insert or clear passes the transfer, a compare step in which every cell compares its
// entry with the new value, and an execute step: the cells at and behind the insert point
// shift one place toward the tail (append or insert, when not full) or all cells empty
// (clear). A read out then rotates the row by one cell per emitted entry through the shared
// output register; back-pressure on the output stalls the execute and read steps.

module sorted_insertion_list
  import sil_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // [31:0] item_value
  input  logic [1:0]  s_axis_tuser_i,  // [1:0] req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // [31:0] out_value
  output logic [1:0]  m_axis_tuser_o,  // [1:0] status
  output logic        m_axis_tlast_o   // last_of_run
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_READ = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [1:0]            req_q;
  logic [ValueWidth-1:0] val_q;
  logic [CW-1:0]         count_q, count_d;
  logic [IW-1:0]         rd_q, rd_d;

  logic                  m_valid_q, m_valid_d;
  logic [ValueWidth-1:0] m_data_q, m_data_d;
  logic [1:0]            m_user_q, m_user_d;
  logic                  m_last_q, m_last_d;

  cell_ctrl_t            ctrl;
  logic [ValueWidth-1:0] value_w [DEPTH];
  logic [DEPTH-1:0]      valid_w;
  logic [DEPTH-1:0]      hit_w;
  logic [DEPTH-1:0]      mask_w;

  logic in_xfer;
  logic out_free;
  logic full;
  logic read_last;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign full            = valid_w[DEPTH-1];
  assign read_last       = (CW'(rd_q) + CW'(1)) == count_q;

  // Cells at and behind the first hit form a contiguous run up to the top.
  assign mask_w = hit_w | ((~hit_w) + DEPTH'(1));

  genvar g;
  for (g = 0; g < DEPTH; g++) begin : gen_cell
    logic [ValueWidth-1:0] prev_value;
    logic                  prev_valid;
    logic                  prev_mask;
    logic [ValueWidth-1:0] next_value;
    logic                  next_valid;

    if (g == 0) begin : gen_first
      assign prev_value = val_q;
      assign prev_valid = 1'b0;
      assign prev_mask  = 1'b0;
    end else begin : gen_mid
      assign prev_value = value_w[g-1];
      assign prev_valid = valid_w[g-1];
      assign prev_mask  = mask_w[g-1];
    end

    if (g == DEPTH - 1) begin : gen_last
      assign next_value = value_w[0];
      assign next_valid = 1'b0;
    end else begin : gen_inner
      assign next_value = value_w[g+1];
      assign next_valid = valid_w[g+1];
    end

    sil_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_value_i (prev_value),
      .prev_valid_i (prev_valid),
      .prev_mask_i  (prev_mask),
      .next_value_i (next_value),
      .next_valid_i (next_valid),
      .head_value_i (value_w[0]),
      .mask_i       (mask_w[g]),
      .value_o      (value_w[g]),
      .valid_o      (valid_w[g]),
      .hit_o        (hit_w[g])
    );
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    rd_d      = rd_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    m_last_d  = m_last_q;

    ctrl.op        = CELL_HOLD;
    ctrl.is_insert = (req_q == REQ_INSERT);
    ctrl.value     = val_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        ctrl.op = CELL_CMP;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          m_data_d = '0;
          m_last_d = 1'b1;
          m_user_d = STAT_OK;
          state_d  = S_IDLE;
          unique case (req_q)
            REQ_READ: begin
              if (count_q == '0) begin
                m_valid_d = 1'b1;
                m_user_d  = STAT_EMPTY;
              end else begin
                rd_d    = '0;
                state_d = S_READ;
              end
            end
            REQ_CLEAR: begin
              ctrl.op   = CELL_CLEAR;
              count_d   = '0;
              m_valid_d = 1'b1;
            end
            REQ_APPEND, REQ_INSERT: begin
              m_valid_d = 1'b1;
              if (full) begin
                m_user_d = STAT_FULL;
              end else begin
                ctrl.op = CELL_SHIFT_IN;
                count_d = count_q + CW'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          ctrl.op   = CELL_ROTATE;
          m_valid_d = 1'b1;
          m_data_d  = value_w[0];
          m_user_d  = STAT_OK;
          m_last_d  = read_last;
          rd_d      = rd_q + IW'(1);
          if (read_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      rd_q      <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rd_q      <= rd_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q <= s_axis_tuser_i;
      val_q <= s_axis_tdata_i;
    end
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
    m_last_q <= m_last_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tlast_o  = m_last_q;

  // The occupied cells always form one run starting at the head.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_w & (valid_w + DEPTH'(1))) == '0)
    else $error("occupied cells are not contiguous from the head");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_w) == int'(count_q))
    else $error("entry count disagrees with occupied cells");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (count_q != '0))
    else $error("read out running on an empty list");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ && out_free && read_last) |=> (state_q == S_IDLE && m_axis_tlast_o))
    else $error("read out did not end on the tail entry");

endmodule
